// ----- hdl/dgst_pkg.sv -----
// ============================================================================
// dgst_pkg: shared types and constants for the disc grid sector touch block
// Register indexes, fixed field widths and the restoring division step.
// ============================================================================
package dgst_pkg;

    localparam int CELL_BITS      = 16;
    localparam int GRID_BITS      = 7;
    localparam int RADIUS_BITS    = 20;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;
    localparam int MASK_BITS      = 8;
    localparam int SQ_BITS        = 2 * CELL_BITS;
    localparam int RSQ_BITS       = 2 * RADIUS_BITS;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_CELL_WIDTH  = 3'd0;
    localparam cfg_index_t REG_CELL_HEIGHT = 3'd1;
    localparam cfg_index_t REG_GRID_COLS   = 3'd2;
    localparam cfg_index_t REG_GRID_ROWS   = 3'd3;
    localparam cfg_index_t REG_RADIUS_Q4   = 3'd4;

    // One restoring division step. The partial remainder is below the divisor
    // on entry, so the result fits back into CELL_BITS. Bit CELL_BITS of the
    // return value is the quotient bit.
    function automatic logic [CELL_BITS:0] div_step(
        input logic [CELL_BITS-1:0] rem,
        input logic                 dvd_bit,
        input logic [CELL_BITS-1:0] dvs
    );
        logic [CELL_BITS:0] trial;
        logic [CELL_BITS:0] diff;
        trial = {rem, dvd_bit};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs})
        begin
            div_step = {1'b1, diff[CELL_BITS-1:0]};
        end
        else
        begin
            div_step = {1'b0, trial[CELL_BITS-1:0]};
        end
    endfunction

endpackage

// ----- hdl/disc_grid_sector_touch.sv -----
// ============================================================================
// disc_grid_sector_touch: grid cell and neighbour reach of a disc
// Finds the cell holding a disc centre and the neighbouring cells it reaches.
// ============================================================================
// Usage
// A position word (pos_x, pos_y) is taken at every rising edge where start
// is high and busy is low. busy is never raised: the block is fully
// pipelined and takes a new word in every cycle, back to back.
// Each word yields exactly one result word, shown on cell_row, cell_col and
// touch_mask for one cycle with done high. Results leave in the order the
// positions arrived. The divider resolves one quotient bit per stage for
// both coordinates at once (COORD_BITS stages); behind it come an edge test
// stage, a squaring stage and a corner compare stage.
// Configuration is written through cfg_we, cfg_index and cfg_data, one
// register per edge, and must only change while no word is in flight.
// Reset clears every valid bit, so no result is produced for words in flight,
// and returns the registers to width 1, height 1, one column, one row and
// radius zero. The receiver has no way to stall the block: each result must
// be captured in the cycle it is shown.
// ============================================================================
module disc_grid_sector_touch
    import dgst_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [COORD_BITS-1:0]     pos_x,
    input  logic [COORD_BITS-1:0]     pos_y,
    output logic                      done,
    output logic [CELL_BITS-1:0]      cell_row,
    output logic [CELL_BITS-1:0]      cell_col,
    output logic [MASK_BITS-1:0]      touch_mask,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int EXT_BITS = COORD_BITS + 1;

    // Configuration registers. The cell sizes are held as the divisors, with
    // a written zero already replaced by one.
    logic [CELL_BITS-1:0]   cell_width_reg;
    logic [CELL_BITS-1:0]   cell_height_reg;
    logic [GRID_BITS-1:0]   grid_cols_reg;
    logic [GRID_BITS-1:0]   grid_rows_reg;
    logic [RADIUS_BITS-1:0] radius_reg;

    // The squared radius is registered from the radius. It is only used at the
    // corner stage, which a word taken after the change reaches only after the
    // divider, edge test and squaring stages.
    logic [SQ_BITS-1:0]     rsq_reg;
    logic [RSQ_BITS-1:0]    rsq_next;

    // Divider outputs.
    logic                   div_valid;
    logic [COORD_BITS-1:0]  col_q;
    logic [COORD_BITS-1:0]  row_q;
    logic [CELL_BITS-1:0]   dl;
    logic [CELL_BITS-1:0]   du;

    // Edge test stage.
    logic [CELL_BITS-1:0]   dr;
    logic [CELL_BITS-1:0]   dd;
    logic                   left;
    logic                   up;
    logic                   right;
    logic                   down;
    logic [EXT_BITS-1:0]    row_e;
    logic [EXT_BITS-1:0]    col_e;
    logic [EXT_BITS-1:0]    rows_e;
    logic [EXT_BITS-1:0]    cols_e;
    logic                   row_in_m;
    logic                   row_in_0;
    logic                   row_in_p;
    logic                   col_in_m;
    logic                   col_in_0;
    logic                   col_in_p;
    logic [3:0]             edge_next;
    logic [3:0]             diag_next;
    logic [CELL_BITS-1:0]   ca_next;
    logic [CELL_BITS-1:0]   cb_next;

    logic                   va_reg;
    logic [3:0]             edge_a_reg;
    logic [3:0]             diag_a_reg;
    logic [CELL_BITS-1:0]   ca_reg;
    logic [CELL_BITS-1:0]   cb_reg;
    logic [CELL_BITS-1:0]   row_a_reg;
    logic [CELL_BITS-1:0]   col_a_reg;

    // Squaring stage.
    logic                   vb_reg;
    logic [3:0]             edge_b_reg;
    logic [3:0]             diag_b_reg;
    logic [SQ_BITS-1:0]     sqa_reg;
    logic [SQ_BITS-1:0]     sqb_reg;
    logic [CELL_BITS-1:0]   row_b_reg;
    logic [CELL_BITS-1:0]   col_b_reg;

    // Corner compare and output stage.
    logic [SQ_BITS:0]       sq_sum;
    logic                   corner_hit;
    logic                   done_reg;
    logic [MASK_BITS-1:0]   touch_mask_reg;
    logic [CELL_BITS-1:0]   cell_row_reg;
    logic [CELL_BITS-1:0]   cell_col_reg;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Configuration port. A zero cell size divides as a size of one, so the
    // replacement is made as the register is written and the divider sees
    // the final value from the very next word.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= CELL_BITS'(1);
            cell_height_reg <= CELL_BITS'(1);
            grid_cols_reg   <= GRID_BITS'(1);
            grid_rows_reg   <= GRID_BITS'(1);
            radius_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_WIDTH:  cell_width_reg  <= (cfg_data[CELL_BITS-1:0] == '0) ?
                                                    CELL_BITS'(1) :
                                                    cfg_data[CELL_BITS-1:0];
                REG_CELL_HEIGHT: cell_height_reg <= (cfg_data[CELL_BITS-1:0] == '0) ?
                                                    CELL_BITS'(1) :
                                                    cfg_data[CELL_BITS-1:0];
                REG_GRID_COLS:   grid_cols_reg   <= cfg_data[GRID_BITS-1:0];
                REG_GRID_ROWS:   grid_rows_reg   <= cfg_data[GRID_BITS-1:0];
                REG_RADIUS_Q4:   radius_reg      <= cfg_data[RADIUS_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Every corner distance is a whole number of board units scaled by 16,
    // so both sides of the corner test carry a factor of 256; dividing it out
    // of the squared radius and rounding down keeps the comparison exact.
    assign rsq_next = radius_reg * radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsq_reg <= '0;
        end
        else
        begin
            rsq_reg <= rsq_next[RSQ_BITS-1:8];
        end
    end

    // ------------------------------------------------------------------
    // Division of both coordinates by the cell size.
    // ------------------------------------------------------------------
    dgst_div2 #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .dvd_x     (pos_x),
        .dvd_y     (pos_y),
        .dvs_x     (cell_width_reg),
        .dvs_y     (cell_height_reg),
        .out_valid (div_valid),
        .quot_x    (col_q),
        .rem_x     (dl),
        .quot_y    (row_q),
        .rem_y     (du)
    );

    // ------------------------------------------------------------------
    // Edge tests, grid bounds and choice of the diagonal candidate.
    // ------------------------------------------------------------------
    assign dr = cell_width_reg - dl;
    assign dd = cell_height_reg - du;

    assign left  = {dl, 4'b0000} <= radius_reg;
    assign up    = {du, 4'b0000} <= radius_reg;
    assign right = {dr, 4'b0000} <= radius_reg;
    assign down  = {dd, 4'b0000} <= radius_reg;

    assign row_e  = {1'b0, row_q};
    assign col_e  = {1'b0, col_q};
    assign rows_e = EXT_BITS'(grid_rows_reg);
    assign cols_e = EXT_BITS'(grid_cols_reg);

    // Whether the row above, this row and the row below lie in the grid;
    // likewise for the columns to the west, here and to the east.
    assign row_in_m = (row_q != '0) && (row_e <= rows_e);
    assign row_in_0 = row_e < rows_e;
    assign row_in_p = (row_e + EXT_BITS'(1)) < rows_e;
    assign col_in_m = (col_q != '0) && (col_e <= cols_e);
    assign col_in_0 = col_e < cols_e;
    assign col_in_p = (col_e + EXT_BITS'(1)) < cols_e;

    assign edge_next[0] = left  && row_in_0 && col_in_m;
    assign edge_next[1] = up    && row_in_m && col_in_0;
    assign edge_next[2] = right && row_in_0 && col_in_p;
    assign edge_next[3] = down  && row_in_p && col_in_0;

    // Only the first pair of edge hits, in the order north-west, north-east,
    // south-east, south-west, goes on to the corner test.
    always_comb
    begin
        diag_next = 4'b0000;
        ca_next   = dl;
        cb_next   = du;
        if (left && up)
        begin
            diag_next[0] = row_in_m && col_in_m;
        end
        else if (up && right)
        begin
            diag_next[1] = row_in_m && col_in_p;
            ca_next      = dr;
        end
        else if (right && down)
        begin
            diag_next[2] = row_in_p && col_in_p;
            ca_next      = dr;
            cb_next      = dd;
        end
        else if (down && left)
        begin
            diag_next[3] = row_in_p && col_in_m;
            cb_next      = dd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_a_reg <= edge_next;
        diag_a_reg <= diag_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        row_a_reg  <= CELL_BITS'(row_q);
        col_a_reg  <= CELL_BITS'(col_q);
    end

    // ------------------------------------------------------------------
    // Squares of the two corner offsets.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_b_reg <= edge_a_reg;
        diag_b_reg <= diag_a_reg;
        sqa_reg    <= ca_reg * ca_reg;
        sqb_reg    <= cb_reg * cb_reg;
        row_b_reg  <= row_a_reg;
        col_b_reg  <= col_a_reg;
    end

    // ------------------------------------------------------------------
    // Corner compare and result register.
    // ------------------------------------------------------------------
    assign sq_sum     = {1'b0, sqa_reg} + {1'b0, sqb_reg};
    assign corner_hit = sq_sum <= {1'b0, rsq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        touch_mask_reg <= {diag_b_reg & {4{corner_hit}}, edge_b_reg};
        cell_row_reg   <= row_b_reg;
        cell_col_reg   <= col_b_reg;
    end

    assign done       = done_reg;
    assign touch_mask = touch_mask_reg;
    assign cell_row   = cell_row_reg;
    assign cell_col   = cell_col_reg;

endmodule

// ----- hdl/dgst_div2.sv -----
// ============================================================================
// dgst_div2: two-lane pipelined restoring divider
// One quotient bit per stage for both coordinates; a word enters every cycle.
// ============================================================================
module dgst_div2
    import dgst_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] dvd_x,
    input  logic [COORD_BITS-1:0] dvd_y,
    input  logic [CELL_BITS-1:0]  dvs_x,
    input  logic [CELL_BITS-1:0]  dvs_y,
    output logic                  out_valid,
    output logic [COORD_BITS-1:0] quot_x,
    output logic [CELL_BITS-1:0]  rem_x,
    output logic [COORD_BITS-1:0] quot_y,
    output logic [CELL_BITS-1:0]  rem_y
);

    logic [COORD_BITS-1:0] valid_reg;
    logic [CELL_BITS-1:0]  remx_reg [COORD_BITS];
    logic [CELL_BITS-1:0]  remy_reg [COORD_BITS];
    logic [COORD_BITS-1:0] dvx_reg  [COORD_BITS];
    logic [COORD_BITS-1:0] dvy_reg  [COORD_BITS];

    // The dividend word shifts left by one each stage and takes the new
    // quotient bit at the bottom, so after the last stage it holds the quotient.
    for (genvar s = 0; s < COORD_BITS; s++)
    begin : g_stage
        logic [CELL_BITS-1:0]  remx_src;
        logic [CELL_BITS-1:0]  remy_src;
        logic [COORD_BITS-1:0] dvx_src;
        logic [COORD_BITS-1:0] dvy_src;
        logic                  valid_src;
        logic [CELL_BITS:0]    stepx;
        logic [CELL_BITS:0]    stepy;

        if (s == 0)
        begin : g_first
            assign remx_src  = '0;
            assign remy_src  = '0;
            assign dvx_src   = dvd_x;
            assign dvy_src   = dvd_y;
            assign valid_src = in_valid;
        end
        else
        begin : g_rest
            assign remx_src  = remx_reg[s-1];
            assign remy_src  = remy_reg[s-1];
            assign dvx_src   = dvx_reg[s-1];
            assign dvy_src   = dvy_reg[s-1];
            assign valid_src = valid_reg[s-1];
        end

        assign stepx = div_step(remx_src, dvx_src[COORD_BITS-1], dvs_x);
        assign stepy = div_step(remy_src, dvy_src[COORD_BITS-1], dvs_y);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            remx_reg[s] <= stepx[CELL_BITS-1:0];
            remy_reg[s] <= stepy[CELL_BITS-1:0];
            dvx_reg[s]  <= {dvx_src[COORD_BITS-2:0], stepx[CELL_BITS]};
            dvy_reg[s]  <= {dvy_src[COORD_BITS-2:0], stepy[CELL_BITS]};
        end
    end

    assign out_valid = valid_reg[COORD_BITS-1];
    assign quot_x    = dvx_reg[COORD_BITS-1];
    assign rem_x     = remx_reg[COORD_BITS-1];
    assign quot_y    = dvy_reg[COORD_BITS-1];
    assign rem_y     = remy_reg[COORD_BITS-1];

endmodule

// ----- hdl/dgst_checker.sv -----
// ============================================================================
// dgst_checker: port-level checks for disc_grid_sector_touch
// Checks result timing and the shape of the touch mask on the top ports.
// ============================================================================
module dgst_checker
    import dgst_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [COORD_BITS-1:0]     pos_x,
    input logic [COORD_BITS-1:0]     pos_y,
    input logic                      done,
    input logic [CELL_BITS-1:0]      cell_row,
    input logic [CELL_BITS-1:0]      cell_col,
    input logic [MASK_BITS-1:0]      touch_mask,
    input logic                      cfg_we,
    input logic [CFG_INDEX_BITS-1:0] cfg_index,
    input logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int LATENCY = COORD_BITS + 3;

    // The pipeline never refuses a word.
    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Every accepted word gives a result after the fixed latency.
    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after accepted word");

    // No result appears without a word accepted the latency earlier.
    a_no_stray_result : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching word");

    // At most one diagonal neighbour is ever reported.
    a_one_diagonal : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0(touch_mask[7:4]))
        else $error("more than one diagonal marked");

endmodule

bind disc_grid_sector_touch dgst_checker #(
    .COORD_BITS (COORD_BITS)
) u_dgst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .done       (done),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .touch_mask (touch_mask),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
);

// ----- tb/tb_disc_grid_sector_touch.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_disc_grid_sector_touch: self-checking bench for the disc grid sector touch
// Streams disc centres through the block under several grid, cell and radius
// settings and checks every result word against an in-bench cell locator.
// ============================================================================
module tb_disc_grid_sector_touch;

    import dgst_pkg::*;

    localparam int COORD_BITS   = 16;
    // Divider stages plus edge, squaring and corner stages.
    localparam int PIPE_LATENCY = COORD_BITS + 3;

    // Bit positions within touch_mask.
    localparam int TOUCH_W  = 0;
    localparam int TOUCH_N  = 1;
    localparam int TOUCH_E  = 2;
    localparam int TOUCH_S  = 3;
    localparam int TOUCH_NW = 4;
    localparam int TOUCH_NE = 5;
    localparam int TOUCH_SE = 6;
    localparam int TOUCH_SW = 7;

    // An index with no register behind it; a write there must change nothing.
    localparam cfg_index_t REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } position_t;

    typedef struct packed {
        logic [CELL_BITS-1:0] row;
        logic [CELL_BITS-1:0] col;
        logic [MASK_BITS-1:0] mask;
    } cell_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [COORD_BITS-1:0]     pos_x;
    logic [COORD_BITS-1:0]     pos_y;
    logic                      done;
    logic [CELL_BITS-1:0]      cell_row;
    logic [CELL_BITS-1:0]      cell_col;
    logic [MASK_BITS-1:0]      touch_mask;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // The bench's own copy of the grid registers, kept in step with every write.
    logic [CELL_BITS-1:0]   grid_w;
    logic [CELL_BITS-1:0]   grid_h;
    logic [GRID_BITS-1:0]   grid_cols;
    logic [GRID_BITS-1:0]   grid_rows;
    logic [RADIUS_BITS-1:0] grid_rad;

    // Positions waiting to be driven, and the cells predicted for positions
    // that the block has taken but not yet answered.
    position_t    position_queue[$];
    cell_result_t expected_cells[$];

    // issued_cnt counts words put on the bus, taken_cnt words the block took.
    // They differ only while a word is still waiting on the bus.
    int issued_cnt = 0;
    int taken_cnt  = 0;
    int fail_cnt   = 0;

    // Sender burst shaping.
    int burst_left = 1;
    int gap_left   = 0;

    disc_grid_sector_touch #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .done       (done),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .touch_mask (touch_mask),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // A generous ceiling on the whole run; a healthy run ends long before it.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Cell locator
    // ------------------------------------------------------------------------

    // True when the neighbour at (r, c) lies inside the configured grid. A
    // grid size of zero leaves no neighbour inside at all.
    function automatic bit in_grid(input int r, input int c);
        return r >= 0 && c >= 0 && r < int'(grid_rows) && c < int'(grid_cols);
    endfunction

    // Exact corner test in Q4: (16a)^2 + (16b)^2 <= radius^2, no rounding.
    function automatic bit corner_reached(input logic [CELL_BITS-1:0] a,
                                          input logic [CELL_BITS-1:0] b);
        logic [63:0] a16;
        logic [63:0] b16;
        logic [63:0] r64;
        a16 = {44'd0, a, 4'd0};
        b16 = {44'd0, b, 4'd0};
        r64 = {44'd0, grid_rad};
        return a16 * a16 + b16 * b16 <= r64 * r64;
    endfunction

    // Works out the cell that holds a centre and the neighbours the disc
    // reaches under the current register copy.
    function automatic cell_result_t locate_disc(input logic [COORD_BITS-1:0] px,
                                                 input logic [COORD_BITS-1:0] py);
        logic [CELL_BITS-1:0] w;
        logic [CELL_BITS-1:0] h;
        logic [CELL_BITS-1:0] col;
        logic [CELL_BITS-1:0] row;
        logic [CELL_BITS-1:0] dl;
        logic [CELL_BITS-1:0] du;
        logic [CELL_BITS-1:0] dr;
        logic [CELL_BITS-1:0] dd;
        logic                 hit_w;
        logic                 hit_n;
        logic                 hit_e;
        logic                 hit_s;
        int                   r;
        int                   c;
        cell_result_t         res;

        // A zero cell size counts as one.
        w   = (grid_w == '0) ? CELL_BITS'(1) : grid_w;
        h   = (grid_h == '0) ? CELL_BITS'(1) : grid_h;
        col = px / w;
        row = py / h;
        dl  = px - col * w;
        du  = py - row * h;
        dr  = w - dl;
        dd  = h - du;

        hit_w = {dl, 4'd0} <= grid_rad;
        hit_n = {du, 4'd0} <= grid_rad;
        hit_e = {dr, 4'd0} <= grid_rad;
        hit_s = {dd, 4'd0} <= grid_rad;

        r = int'(row);
        c = int'(col);
        res.row  = row;
        res.col  = col;
        res.mask = '0;

        // Only the first qualifying diagonal is ever tested.
        if (hit_w && hit_n)
        begin
            if (corner_reached(dl, du) && in_grid(r - 1, c - 1))
                res.mask[TOUCH_NW] = 1'b1;
        end
        else if (hit_n && hit_e)
        begin
            if (corner_reached(dr, du) && in_grid(r - 1, c + 1))
                res.mask[TOUCH_NE] = 1'b1;
        end
        else if (hit_e && hit_s)
        begin
            if (corner_reached(dr, dd) && in_grid(r + 1, c + 1))
                res.mask[TOUCH_SE] = 1'b1;
        end
        else if (hit_s && hit_w)
        begin
            if (corner_reached(dl, dd) && in_grid(r + 1, c - 1))
                res.mask[TOUCH_SW] = 1'b1;
        end

        if (hit_w && in_grid(r, c - 1))
            res.mask[TOUCH_W] = 1'b1;
        if (hit_n && in_grid(r - 1, c))
            res.mask[TOUCH_N] = 1'b1;
        if (hit_e && in_grid(r, c + 1))
            res.mask[TOUCH_E] = 1'b1;
        if (hit_s && in_grid(r + 1, c))
            res.mask[TOUCH_S] = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------

    // Inputs move on the falling edge only. A word stays on the bus until the
    // block has taken it; the sender then carries on with its burst or sits
    // out a gap of random length before the next one.
    always @(negedge clk)
    begin : drive_words
        position_t word;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (issued_cnt != taken_cnt)
        begin
            // The current word has not been taken yet, so it is held.
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left = gap_left - 1;
        end
        else if (position_queue.size() > 0)
        begin
            word       = position_queue.pop_front();
            pos_x      <= word.x;
            pos_y      <= word.y;
            start      <= 1'b1;
            issued_cnt = issued_cnt + 1;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            else
            begin
                burst_left = burst_left - 1;
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------------

    // Sampling happens on the rising edge. A word taken at this edge has its
    // cell predicted first, so that even a block with no delay at all would be
    // checked correctly. The block cannot be stalled, so every strobe is a
    // result that must be matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        cell_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_cells.push_back(locate_disc(pos_x, pos_y));
                taken_cnt = taken_cnt + 1;
            end
            if (done)
            begin
                if (expected_cells.size() == 0)
                begin
                    $error("result word with no position outstanding: row %0d col %0d mask %b",
                           cell_row, cell_col, touch_mask);
                    fail_cnt = fail_cnt + 1;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (cell_row !== want.row)
                    begin
                        $error("cell_row: expected %0d, got %0d", want.row, cell_row);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (cell_col !== want.col)
                    begin
                        $error("cell_col: expected %0d, got %0d", want.col, cell_col);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (touch_mask !== want.mask)
                    begin
                        $error("touch_mask: expected %b, got %b", want.mask, touch_mask);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_position(input int x, input int y);
        position_t word;
        word.x = COORD_BITS'(x);
        word.y = COORD_BITS'(y);
        position_queue.push_back(word);
    endtask

    // One coordinate, mostly placed just inside either edge of a cell so that
    // the radius comparisons land on both sides of their thresholds. The cell
    // index runs up to two cells past the grid so that border cells and outside
    // cells turn up as well.
    function automatic int pick_coord(input int size, input int count, input int reach);
        int     cell_i;
        int     off;
        int     span;
        longint v;
        span   = (reach < size - 1) ? reach : size - 1;
        cell_i = $urandom_range(0, count + 1);
        case ($urandom_range(0, 2))
            0:       off = $urandom_range(0, span);
            1:       off = size - 1 - $urandom_range(0, span);
            default: off = $urandom_range(0, size - 1);
        endcase
        v = longint'(cell_i) * size + off;
        if (v > 65535)
            v = $urandom_range(0, 65535);
        return int'(v);
    endfunction

    // Random positions shaped for the current settings, with some fully random
    // words and some at the corners of the coordinate range.
    task automatic queue_random(input int count);
        int n;
        int reach;
        int eff_w;
        int eff_h;
        reach = int'(grid_rad >> 4) + 1;
        eff_w = (grid_w == '0) ? 1 : int'(grid_w);
        eff_h = (grid_h == '0) ? 1 : int'(grid_h);
        for (n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0: queue_position($urandom_range(0, 65535), $urandom_range(0, 65535));
                1: queue_position($urandom_range(0, 1) * 65535,
                                  $urandom_range(0, 1) * 65535);
                default: queue_position(pick_coord(eff_w, int'(grid_cols), reach),
                                        pick_coord(eff_h, int'(grid_rows), reach));
            endcase
        end
    endtask

    // Waits until every queued word has been taken and answered, then lets the
    // pipeline run empty before any register is touched.
    task automatic wait_for_drain;
        while (position_queue.size() != 0 || issued_cnt != taken_cnt
               || expected_cells.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // One register write on the falling edge; the bench copy follows the
    // register, masked to the register's width.
    task automatic write_grid_reg(input cfg_index_t idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CELL_WIDTH:  grid_w    = data[CELL_BITS-1:0];
            REG_CELL_HEIGHT: grid_h    = data[CELL_BITS-1:0];
            REG_GRID_COLS:   grid_cols = data[GRID_BITS-1:0];
            REG_GRID_ROWS:   grid_rows = data[GRID_BITS-1:0];
            REG_RADIUS_Q4:   grid_rad  = data[RADIUS_BITS-1:0];
            default:         ;
        endcase
    endtask

    // Writes all five registers. With junk set, the data bits above each
    // register's width carry random values that the block must ignore.
    task automatic program_grid(input int w, input int h, input int cols,
                                input int rows, input int rad, input bit junk);
        logic [CFG_DATA_BITS-1:0] noise;
        noise = junk ? CFG_DATA_BITS'($urandom) : '0;
        write_grid_reg(REG_CELL_WIDTH,  CFG_DATA_BITS'(w & 'hFFFF) | (noise & 20'hF0000));
        write_grid_reg(REG_CELL_HEIGHT, CFG_DATA_BITS'(h & 'hFFFF) | (noise & 20'hF0000));
        write_grid_reg(REG_GRID_COLS,   CFG_DATA_BITS'(cols & 'h7F) | (noise & 20'hFFF80));
        write_grid_reg(REG_GRID_ROWS,   CFG_DATA_BITS'(rows & 'h7F) | (noise & 20'hFFF80));
        write_grid_reg(REG_RADIUS_Q4,   CFG_DATA_BITS'(rad & 'hFFFFF));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Picks a grid count, mostly in the intended range but now and then zero
    // or above it, since the block uses the count as written.
    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(65, 127);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial
    begin : run_sequence
        int phase;
        int w;
        int h;
        int rad;

        rst_n     = 1'b0;
        start     = 1'b0;
        pos_x     = '0;
        pos_y     = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // Register values after reset.
        grid_w    = CELL_BITS'(1);
        grid_h    = CELL_BITS'(1);
        grid_cols = GRID_BITS'(1);
        grid_rows = GRID_BITS'(1);
        grid_rad  = '0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one-unit cells, a single cell grid and zero radius.
        queue_position(0, 0);
        queue_position(65535, 65535);
        queue_position('hAAAA, 'h5555);
        queue_position('h5555, 'hAAAA);
        wait_for_drain();

        // A 4 by 4 grid of 16 unit cells and a radius of five units. A 3-4-5
        // offset puts the centre exactly on the circle round a corner.
        program_grid(16, 16, 4, 4, 80, 1'b0);
        queue_position(24, 24);         // middle of a cell, nothing reached
        queue_position(19, 20);         // north-west corner exactly on radius
        queue_position(20, 20);         // both edges reached, corner just missed
        queue_position(29, 20);         // north-east corner
        queue_position(29, 28);         // south-east corner
        queue_position(19, 28);         // south-west corner
        queue_position(0, 0);           // top-left cell, neighbours off the grid
        queue_position(63, 63);         // bottom-right cell
        queue_position(17, 40);         // west edge alone
        queue_position(40, 31);         // south edge alone
        queue_position(65535, 0);       // centre far outside the grid
        queue_position(0, 65535);
        wait_for_drain();

        // Largest cells, 64 by 64 grid and the largest radius: every edge is
        // reached, so the diagonal choice always falls on north-west.
        program_grid(65535, 65535, 64, 64, 1048575, 1'b0);
        queue_position(65535, 65535);
        queue_position(0, 0);
        queue_position(32768, 1);
        queue_random(40);
        wait_for_drain();

        // Zero cell sizes count as one, a zero column count leaves nothing
        // inside, and the row count is the largest that fits the register.
        program_grid(0, 0, 0, 127, $urandom_range(0, 64), 1'b1);
        // A write to an index with no register must leave the settings alone.
        write_grid_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
        queue_random(30);
        wait_for_drain();

        // Random settings, each phase drained before the next is written. The
        // first phase uses the smallest legal values everywhere.
        for (phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                program_grid(1, 1, 1, 1, 0, 1'b0);
            end
            else
            begin
                w   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 40);
                h   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 40);
                // The radius mostly lies around the cell size, so that one,
                // two or all edges of a cell come within reach.
                if ($urandom_range(0, 4) == 0)
                    rad = $urandom_range(0, 1048575);
                else
                    rad = $urandom_range(0, 16 * ((w > h) ? w : h) + 32);
                if (rad > 1048575)
                    rad = 1048575;
                program_grid(w, h, pick_count(), pick_count(), rad,
                             $urandom_range(0, 1));
            end
            queue_random(60);
            wait_for_drain();
        end

        // Nothing is outstanding now; a quiet stretch catches stray strobes.
        repeat (2 * PIPE_LATENCY) @(negedge clk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/dgst_pkg.sv
hdl/dgst_div2.sv
hdl/disc_grid_sector_touch.sv
hdl/dgst_checker.sv
tb/tb_disc_grid_sector_touch.sv
